>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property holds at every edge
`define ASSERT_ALWAYS(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(name, expr, msg)
`define ASSERT_IMPLY(name, ante, cons, msg)
`define ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

>>> rtl/tbpg_pkg.sv
// ----------------------------------------------------------------------------
// tbpg_pkg
// types and constants of the tape block pulse generator
// ----------------------------------------------------------------------------
package tbpg_pkg;

  localparam int TIMER_WIDTH_DEF = 24;

  localparam int CFG_WIDTH     = 24;
  localparam int CFG_IDX_WIDTH = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_PILOT_HALF_PERIOD  = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_SYNC_FIRST_LENGTH  = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_SYNC_SECOND_LENGTH = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_ZERO_BIT_LENGTH    = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_ONE_BIT_LENGTH     = 3'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_HEADER_PILOT_COUNT = 3'd5;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_DATA_PILOT_COUNT   = 3'd6;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_PAUSE_LENGTH       = 3'd7;

  // register reset values
  localparam logic [15:0] PILOT_HALF_PERIOD_RST  = 16'd2168;
  localparam logic [15:0] SYNC_FIRST_LENGTH_RST  = 16'd667;
  localparam logic [15:0] SYNC_SECOND_LENGTH_RST = 16'd735;
  localparam logic [15:0] ZERO_BIT_LENGTH_RST    = 16'd855;
  localparam logic [15:0] ONE_BIT_LENGTH_RST     = 16'd1710;
  localparam logic [15:0] HEADER_PILOT_COUNT_RST = 16'd8063;
  localparam logic [15:0] DATA_PILOT_COUNT_RST   = 16'd3223;
  localparam logic [23:0] PAUSE_LENGTH_RST       = 24'd1000;

  // flags at or above this value select the data pilot count
  localparam logic [7:0] FLAG_DATA_MIN = 8'h80;

  // header byte counter codes
  localparam logic [1:0] HDR_NONE     = 2'd0;
  localparam logic [1:0] HDR_LEN_LOW  = 2'd1;
  localparam logic [1:0] HDR_LEN_BOTH = 2'd2;

  // external phase codes
  localparam logic [2:0] PHASE_CODE_START = 3'd0;
  localparam logic [2:0] PHASE_CODE_PILOT = 3'd1;
  localparam logic [2:0] PHASE_CODE_SYNC  = 3'd2;
  localparam logic [2:0] PHASE_CODE_DATA  = 3'd3;
  localparam logic [2:0] PHASE_CODE_PAUSE = 3'd4;

  typedef enum logic [4:0] {
    PH_START = 5'b00001,
    PH_PILOT = 5'b00010,
    PH_SYNC  = 5'b00100,
    PH_DATA  = 5'b01000,
    PH_PAUSE = 5'b10000
  } loader_phase_t;

  typedef struct packed {
    logic [15:0] pilot_half_period;
    logic [15:0] sync_first_length;
    logic [15:0] sync_second_length;
    logic [15:0] zero_bit_length;
    logic [15:0] one_bit_length;
    logic [15:0] header_pilot_count;
    logic [15:0] data_pilot_count;
    logic [23:0] pause_length;
  } tbpg_cfg_t;

  // loader state apart from the pulse timer
  typedef struct packed {
    loader_phase_t phase;
    logic [1:0]    header_bytes_seen;
    logic [15:0]   block_bytes_left;
    logic [7:0]    shift_byte;
    logic [2:0]    bit_position;
    logic [15:0]   pulses_left;
    logic          level;
    logic          byte_wanted;
  } tbpg_state_t;

  typedef struct packed {
    logic       ear_level;
    logic       need_byte;
    logic [2:0] phase;
    logic       tick_held;
  } tbpg_result_t;

  function automatic logic [2:0] phase_code(loader_phase_t ph);
    logic [2:0] code;
    unique case (ph)
      PH_PILOT: code = PHASE_CODE_PILOT;
      PH_SYNC:  code = PHASE_CODE_SYNC;
      PH_DATA:  code = PHASE_CODE_DATA;
      PH_PAUSE: code = PHASE_CODE_PAUSE;
      default:  code = PHASE_CODE_START;
    endcase
    return code;
  endfunction

endpackage

>>> rtl/tap_block_pulse_generator.sv
// ----------------------------------------------------------------------------
// tap_block_pulse_generator
// turns tape blocks into a cassette ear signal, one result per request
// ----------------------------------------------------------------------------
// Each request is either one tick of tape time (action 0) or the next tape
// byte (action 1): a block is a two-byte length, low byte first, then a flag
// and data, and it plays as a pilot tone, two sync pulses, two pulses per
// data bit (msb first) and a pause. need_byte tells the source when the next
// byte is due; a tick sent while a byte is due is flagged in tick_held and
// has no effect. Every request gives exactly one result: the ear level during
// that tick and the need_byte, phase and tick_held after it. The block takes
// one request per clock; the result is registered in the output register, and
// a new request is taken as long as that register is empty or being drained.
// The clock rate is set by the pulse timer path (a TIMER_WIDTH+1 bit increment
// and compare after the pulse length select). The user must write the
// configuration registers through cfg_write/cfg_index/cfg_data only while no
// request is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module tap_block_pulse_generator #(
  parameter int TIMER_WIDTH = tbpg_pkg::TIMER_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration write port
  input  logic                                  cfg_write,
  input  logic [tbpg_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
  input  logic [tbpg_pkg::CFG_WIDTH-1:0]        cfg_data,
  // request channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  action,
  input  logic [7:0]                            tape_byte,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  ear_level,
  output logic                                  need_byte,
  output logic [2:0]                            phase,
  output logic                                  tick_held
);
  import tbpg_pkg::*;

`include "assert_macros.svh"

  tbpg_cfg_t              cfg;
  tbpg_state_t            state;
  tbpg_state_t            state_next;
  logic [TIMER_WIDTH-1:0] pulse_length;
  logic [TIMER_WIDTH-1:0] pulse_length_next;
  logic [TIMER_WIDTH-1:0] tick_count;
  logic [TIMER_WIDTH-1:0] tick_count_next;
  tbpg_result_t           result;
  logic                   in_accept;

  // the output register frees up when its result is taken
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pilot_half_period  <= PILOT_HALF_PERIOD_RST;
      cfg.sync_first_length  <= SYNC_FIRST_LENGTH_RST;
      cfg.sync_second_length <= SYNC_SECOND_LENGTH_RST;
      cfg.zero_bit_length    <= ZERO_BIT_LENGTH_RST;
      cfg.one_bit_length     <= ONE_BIT_LENGTH_RST;
      cfg.header_pilot_count <= HEADER_PILOT_COUNT_RST;
      cfg.data_pilot_count   <= DATA_PILOT_COUNT_RST;
      cfg.pause_length       <= PAUSE_LENGTH_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_PILOT_HALF_PERIOD:  cfg.pilot_half_period  <= cfg_data[15:0];
        CFG_SYNC_FIRST_LENGTH:  cfg.sync_first_length  <= cfg_data[15:0];
        CFG_SYNC_SECOND_LENGTH: cfg.sync_second_length <= cfg_data[15:0];
        CFG_ZERO_BIT_LENGTH:    cfg.zero_bit_length    <= cfg_data[15:0];
        CFG_ONE_BIT_LENGTH:     cfg.one_bit_length     <= cfg_data[15:0];
        CFG_HEADER_PILOT_COUNT: cfg.header_pilot_count <= cfg_data[15:0];
        CFG_DATA_PILOT_COUNT:   cfg.data_pilot_count   <= cfg_data[15:0];
        CFG_PAUSE_LENGTH:       cfg.pause_length       <= cfg_data[23:0];
        default:                cfg.pause_length       <= cfg.pause_length;
      endcase
    end
  end

  // loader next-state logic for the request at the input
  tbpg_step #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_step (
    .cfg               (cfg),
    .cur               (state),
    .pulse_length      (pulse_length),
    .tick_count        (tick_count),
    .action            (action),
    .tape_byte         (tape_byte),
    .nxt               (state_next),
    .pulse_length_next (pulse_length_next),
    .tick_count_next   (tick_count_next),
    .result            (result)
  );

  // loader state only moves on an accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase             <= PH_START;
      state.header_bytes_seen <= HDR_NONE;
      state.block_bytes_left  <= '0;
      state.shift_byte        <= '0;
      state.bit_position      <= '0;
      state.pulses_left       <= '0;
      state.level             <= 1'b0;
      state.byte_wanted       <= 1'b1;
      pulse_length            <= '0;
      tick_count              <= '0;
    end else if (in_accept) begin
      state        <= state_next;
      pulse_length <= pulse_length_next;
      tick_count   <= tick_count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      ear_level <= result.ear_level;
      need_byte <= result.need_byte;
      phase     <= result.phase;
      tick_held <= result.tick_held;
    end
  end

  // tick counter never runs past the current pulse
  `ASSERT_ALWAYS(a_tick_in_pulse, (tick_count == '0) || (tick_count < pulse_length), "tick count beyond pulse length")

  // a held tick leaves the loader untouched
  `ASSERT_NEXT(a_held_no_change, in_accept && !action && state.byte_wanted, (state == $past(state)) && (tick_count == $past(tick_count)), "held tick changed loader state")

  // only a byte request satisfies a pending byte
  `ASSERT_IMPLY(a_byte_clear, $fell(state.byte_wanted), $past(in_accept && action), "byte wait ended without a byte")

  // pilot, sync and pause never wait for a byte
  `ASSERT_IMPLY(a_no_wait_phase, (state.phase == PH_PILOT) || (state.phase == PH_SYNC) || (state.phase == PH_PAUSE), !state.byte_wanted, "byte wanted outside data or start")

endmodule

>>> rtl/tbpg_step.sv
// ----------------------------------------------------------------------------
// tbpg_step
// next-state logic of the loader for one request (a tick or a byte)
// ----------------------------------------------------------------------------
module tbpg_step #(
  parameter int TIMER_WIDTH = tbpg_pkg::TIMER_WIDTH_DEF
) (
  input  tbpg_pkg::tbpg_cfg_t    cfg,
  input  tbpg_pkg::tbpg_state_t  cur,
  input  logic [TIMER_WIDTH-1:0] pulse_length,
  input  logic [TIMER_WIDTH-1:0] tick_count,
  input  logic                   action,
  input  logic [7:0]             tape_byte,
  output tbpg_pkg::tbpg_state_t  nxt,
  output logic [TIMER_WIDTH-1:0] pulse_length_next,
  output logic [TIMER_WIDTH-1:0] tick_count_next,
  output tbpg_pkg::tbpg_result_t result
);
  import tbpg_pkg::*;

  localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_WIDTH) - 33'd1;

  function automatic logic [TIMER_WIDTH-1:0] fit16(logic [15:0] v);
    return TIMER_WIDTH'(v);
  endfunction

  function automatic logic [TIMER_WIDTH-1:0] fit24(logic [23:0] v);
    logic [TIMER_WIDTH-1:0] r;
    if ({9'd0, v} > TIMER_MAX) begin
      r = '1;
    end else begin
      r = TIMER_WIDTH'(v);
    end
    return r;
  endfunction

  logic                 emit;
  logic                 held;
  logic                 data_bit;
  logic [TIMER_WIDTH:0] tick_inc;

  always_comb begin
    nxt               = cur;
    pulse_length_next = pulse_length;
    tick_count_next   = tick_count;
    emit              = 1'b0;
    held              = 1'b0;
    data_bit          = cur.shift_byte[7];

    if (action) begin
      if (cur.byte_wanted) begin
        priority if (cur.phase == PH_START && cur.header_bytes_seen == HDR_NONE) begin
          nxt.block_bytes_left[7:0] = tape_byte;
          nxt.header_bytes_seen     = HDR_LEN_LOW;
        end else if (cur.phase == PH_START && cur.header_bytes_seen == HDR_LEN_LOW) begin
          nxt.block_bytes_left[15:8] = tape_byte;
          nxt.header_bytes_seen      = HDR_LEN_BOTH;
        end else begin
          nxt.shift_byte        = tape_byte;
          nxt.byte_wanted       = 1'b0;
          nxt.header_bytes_seen = HDR_NONE;
        end
      end
    end else if (cur.byte_wanted) begin
      held = 1'b1;
    end else begin
      unique case (cur.phase)
        PH_PILOT: begin
          if (cur.pulses_left == 16'd0) begin
            nxt.phase       = PH_SYNC;
            nxt.pulses_left = 16'd2;
          end
          emit = 1'b1;
        end
        PH_SYNC, PH_DATA: begin
          priority if (cur.phase == PH_SYNC && cur.pulses_left == 16'd2) begin
            pulse_length_next = fit16(cfg.sync_first_length);
          end else if (cur.phase == PH_SYNC && cur.pulses_left == 16'd1) begin
            pulse_length_next = fit16(cfg.sync_second_length);
          end else if (cur.pulses_left == 16'd0) begin
            if (cur.block_bytes_left == 16'd0) begin
              // empty or finished block: straight to the pause
              nxt.phase         = PH_PAUSE;
              nxt.pulses_left   = 16'd1;
              tick_count_next   = '0;
              pulse_length_next = fit24(cfg.pause_length);
            end else begin
              // next data bit, msb first
              nxt.phase        = PH_DATA;
              nxt.shift_byte   = {cur.shift_byte[6:0], 1'b0};
              nxt.bit_position = cur.bit_position + 3'd1;
              if (cur.bit_position == 3'd7) begin
                nxt.block_bytes_left = cur.block_bytes_left - 16'd1;
                if (cur.block_bytes_left != 16'd1) begin
                  nxt.byte_wanted = 1'b1;
                end
              end
              tick_count_next   = '0;
              nxt.pulses_left   = 16'd2;
              pulse_length_next = data_bit ? fit16(cfg.one_bit_length)
                                           : fit16(cfg.zero_bit_length);
            end
          end else begin
            // mid-pulse: keep current timing
            pulse_length_next = pulse_length;
          end
          emit = 1'b1;
        end
        PH_PAUSE: begin
          if (cur.pulses_left == 16'd0) begin
            nxt.phase             = PH_START;
            nxt.byte_wanted       = 1'b1;
            nxt.header_bytes_seen = HDR_NONE;
          end
          emit = 1'b1;
        end
        default: begin
          // block start: set up the pilot tone
          nxt.bit_position  = 3'd0;
          tick_count_next   = '0;
          pulse_length_next = fit16(cfg.pilot_half_period);
          nxt.level         = 1'b1;
          nxt.pulses_left   = (cur.shift_byte < FLAG_DATA_MIN) ? cfg.header_pilot_count
                                                               : cfg.data_pilot_count;
          nxt.phase         = PH_PILOT;
        end
      endcase
    end

    tick_inc = {1'b0, tick_count_next} + {{TIMER_WIDTH{1'b0}}, 1'b1};
    if (emit) begin
      if (tick_inc >= {1'b0, pulse_length_next}) begin
        tick_count_next = '0;
        nxt.pulses_left = nxt.pulses_left - 16'd1;
        nxt.level       = ~nxt.level;
      end else begin
        tick_count_next = tick_inc[TIMER_WIDTH-1:0];
      end
    end
  end

  assign result.ear_level = cur.level;
  assign result.need_byte = nxt.byte_wanted;
  assign result.phase     = phase_code(nxt.phase);
  assign result.tick_held = held;

endmodule
